FILE: hdl/line_plane_intersection_unit_defines.svh
// Assertion macros shared by the line and plane intersection unit
`ifndef LINE_PLANE_INTERSECTION_UNIT_DEFINES_SVH
`define LINE_PLANE_INTERSECTION_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge of clk_i outside reset
`define LPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same-cycle implication
`define LPI_ASSERT_IMP(lbl, ante, cons, msg) `LPI_ASSERT(lbl, (ante) |-> (cons), msg)
// Next-cycle implication
`define LPI_ASSERT_NEXT(lbl, ante, cons, msg) `LPI_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define LPI_ASSERT(lbl, prop, msg)
`define LPI_ASSERT_IMP(lbl, ante, cons, msg)
`define LPI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/lpi_pkg.sv
// Shared widths, types and constants of the line and plane intersection unit
`timescale 1ns / 1ps
`default_nettype none
package lpi_pkg;

  localparam int LANES      = 3;
  localparam int COORD_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int DIR_W      = COORD_W + 1;
  localparam int NPROD_W    = 2 * COORD_W;
  localparam int DPROD_W    = COORD_W + DIR_W;
  localparam int SUM_W      = DPROD_W + 2;
  localparam int NUM_W      = NPROD_W;
  localparam int DEN_W      = DPROD_W;
  localparam int HALF_W     = NUM_W / 2;
  localparam int PP_W       = DIR_W + HALF_W;
  localparam int PROD_W     = DIR_W + NUM_W;
  localparam int CLAMP_LOG2 = 40;
  localparam int QUO_W      = CLAMP_LOG2 + 1;
  localparam int REM_W      = DEN_W;
  localparam int HIT_W      = QUO_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIR_W-1:0]   dir_t;
  typedef logic signed [NPROD_W-1:0] nprod_t;
  typedef logic signed [DPROD_W-1:0] dprod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [NUM_W-1:0]          nmag_t;
  typedef logic [DEN_W-1:0]          dmag_t;
  typedef logic [DIR_W-1:0]          dirmag_t;
  typedef logic [PP_W-1:0]           pp_t;
  typedef logic [PROD_W-1:0]         prod_t;
  typedef logic [QUO_W-1:0]          quo_t;
  typedef logic [REM_W-1:0]          rem_t;
  typedef logic signed [HIT_W-1:0]   hit_t;

  localparam coord_t COORD_MAX    = coord_t'({1'b0, {(COORD_W-1){1'b1}}});
  localparam coord_t COORD_MIN    = coord_t'({1'b1, {(COORD_W-1){1'b0}}});
  localparam coord_t NORMAL_C_RST = coord_t'(1 << FRAC_W);
  localparam quo_t   Q_CLAMP      = quo_t'(1) << CLAMP_LOG2;

  // Divider working state: shared divisor, per-lane partial remainder and
  // a shift register that trades numerator bits for quotient bits.
  typedef struct packed {
    dmag_t                den;
    rem_t [LANES-1:0]     rem;
    quo_t [LANES-1:0]     nq;
  } lpi_div_t;

  // Per-item data that rides along with the divider.
  typedef struct packed {
    logic                 parallel;
    logic [LANES-1:0]     neg;
    logic [LANES-1:0]     ovf;
    coord_t [LANES-1:0]   pt;
  } lpi_side_t;

endpackage
`default_nettype wire

FILE: hdl/lpi_div_pipe.sv
// Restoring divider pipeline, one quotient bit per stage, three lanes
`timescale 1ns / 1ps
`default_nettype none
`include "line_plane_intersection_unit_defines.svh"
module lpi_div_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  lpi_pkg::lpi_div_t  div_i,
  input  lpi_pkg::lpi_side_t side_i,
  output logic               valid_o,
  output lpi_pkg::lpi_div_t  div_o,
  output lpi_pkg::lpi_side_t side_o
);

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  function automatic lpi_pkg::lpi_div_t div_step(input lpi_pkg::lpi_div_t cur);
    lpi_pkg::lpi_div_t       nxt;
    logic [lpi_pkg::REM_W:0] shl;
    logic [lpi_pkg::REM_W:0] dvs;
    logic [lpi_pkg::REM_W:0] dif;
    logic                    ge;
    nxt = cur;
    dvs = {1'b0, cur.den};
    for (int i = 0; i < lpi_pkg::LANES; i++) begin
      shl = {cur.rem[i], cur.nq[i][lpi_pkg::QUO_W-1]};
      dif = shl - dvs;
      ge  = (shl >= dvs);
      nxt.rem[i] = ge ? dif[lpi_pkg::REM_W-1:0] : shl[lpi_pkg::REM_W-1:0];
      nxt.nq[i]  = {cur.nq[i][lpi_pkg::QUO_W-2:0], ge};
    end
    return nxt;
  endfunction

  logic [lpi_pkg::QUO_W-1:0] valid_q;
  lpi_pkg::lpi_div_t         div_q  [lpi_pkg::QUO_W];
  lpi_pkg::lpi_side_t        side_q [lpi_pkg::QUO_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[lpi_pkg::QUO_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    div_q[0]  <= div_step(div_i);
    side_q[0] <= side_i;
    for (int k = 1; k < lpi_pkg::QUO_W; k++) begin
      div_q[k]  <= div_step(div_q[k-1]);
      side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o = valid_q[lpi_pkg::QUO_W-1];
  assign div_o   = div_q[lpi_pkg::QUO_W-1];
  assign side_o  = side_q[lpi_pkg::QUO_W-1];

  `LPI_ASSERT_IMP(a_load_rem_below_den, valid_i && !side_i.parallel, (side_i.ovf[0] || div_i.rem[0] < div_i.den) && (side_i.ovf[1] || div_i.rem[1] < div_i.den) && (side_i.ovf[2] || div_i.rem[2] < div_i.den), "divider loaded with remainder not below divisor")
  `LPI_ASSERT_IMP(a_out_rem_below_den, valid_o && !side_o.parallel, (side_o.ovf[0] || div_o.rem[0] < div_o.den) && (side_o.ovf[1] || div_o.rem[1] < div_o.den) && (side_o.ovf[2] || div_o.rem[2] < div_o.den), "final remainder not below divisor")

endmodule
`default_nettype wire

FILE: hdl/line_plane_intersection_unit.sv
// Top level of the line and plane intersection unit
// Pipeline: valid_o pulses once per item after 7 front stages, 41 divider
//   stages and 2 finish stages.
// Throughput: one item per clock; busy stays low once out of reset. The 41-stage
//   bit-per-stage divider sets the depth, never the rate.
// Reset: clears all valid bits, sets A = B = D = 0 and C = 1.0, and holds busy
//   high until the run flag sets after release. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "line_plane_intersection_unit_defines.svh"
module line_plane_intersection_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  // item channel
  input  logic            start,
  output logic            busy,
  input  logic            func_i,
  input  lpi_pkg::coord_t first_x_i,
  input  lpi_pkg::coord_t first_y_i,
  input  lpi_pkg::coord_t first_z_i,
  input  lpi_pkg::coord_t second_x_i,
  input  lpi_pkg::coord_t second_y_i,
  input  lpi_pkg::coord_t second_z_i,
  // result channel
  output logic            valid_o,
  output lpi_pkg::coord_t hit_x_o,
  output lpi_pkg::coord_t hit_y_o,
  output lpi_pkg::coord_t hit_z_o,
  output logic            parallel_o,
  output logic            saturated_o,
  // configuration write channel
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  lpi_pkg::coord_t cfg_data_i
);

  typedef enum logic [1:0] {
    CFG_NORMAL_A = 2'd0,
    CFG_NORMAL_B = 2'd1,
    CFG_NORMAL_C = 2'd2,
    CFG_OFFSET_D = 2'd3
  } cfg_reg_e;

  localparam int L = lpi_pkg::LANES;

  // ------------------------------------------------------------------
  // Configuration registers: plane normal (A, B, C) and offset D.
  // Writes must arrive only while the pipeline is empty (the block does not
  // enforce it), so the stages read them directly.
  // ------------------------------------------------------------------
  lpi_pkg::coord_t coef_q [L];
  lpi_pkg::coord_t offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= '0;
      coef_q[1] <= '0;
      coef_q[2] <= lpi_pkg::NORMAL_C_RST;
      offset_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_NORMAL_A: coef_q[0] <= cfg_data_i;
        CFG_NORMAL_B: coef_q[1] <= cfg_data_i;
        CFG_NORMAL_C: coef_q[2] <= cfg_data_i;
        CFG_OFFSET_D: offset_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold busy after reset until run_q sets, then take an item every cycle.
  logic run_q;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= 1'b1;
    end
  end

  assign busy   = !run_q;
  assign accept = start && run_q;

  // ------------------------------------------------------------------
  // Stage 1: capture the point and form the direction. In two-point form
  // the direction is the full 33-bit difference, never clipped.
  // ------------------------------------------------------------------
  lpi_pkg::coord_t in_first  [L];
  lpi_pkg::coord_t in_second [L];

  assign in_first[0]  = first_x_i;
  assign in_first[1]  = first_y_i;
  assign in_first[2]  = first_z_i;
  assign in_second[0] = second_x_i;
  assign in_second[1] = second_y_i;
  assign in_second[2] = second_z_i;

  logic            s1_valid_q;
  lpi_pkg::coord_t s1_pt_q  [L];
  lpi_pkg::dir_t   s1_dir_q [L];
  lpi_pkg::dir_t   s1_dir_d [L];

  always_comb begin
    for (int i = 0; i < L; i++) begin
      s1_dir_d[i] = func_i
                  ? lpi_pkg::dir_t'(in_second[i]) - lpi_pkg::dir_t'(in_first[i])
                  : lpi_pkg::dir_t'(in_second[i]);
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: six products, A*P and A*Dir per axis.
  // ------------------------------------------------------------------
  logic             s2_valid_q;
  lpi_pkg::coord_t  s2_pt_q    [L];
  lpi_pkg::dir_t    s2_dir_q   [L];
  lpi_pkg::nprod_t  s2_nprod_q [L];
  lpi_pkg::dprod_t  s2_dprod_q [L];
  lpi_pkg::nprod_t  s2_nprod_d [L];
  lpi_pkg::dprod_t  s2_dprod_d [L];

  always_comb begin
    for (int i = 0; i < L; i++) begin
      s2_nprod_d[i] = coef_q[i] * s1_pt_q[i];
      s2_dprod_d[i] = coef_q[i] * s1_dir_q[i];
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: exact sums. num = n.P + D*2^16, den = n.Dir, both Q.32.
  // ------------------------------------------------------------------
  logic            s3_valid_q;
  lpi_pkg::coord_t s3_pt_q  [L];
  lpi_pkg::dir_t   s3_dir_q [L];
  lpi_pkg::sum_t   s3_num_q;
  lpi_pkg::sum_t   s3_den_q;
  lpi_pkg::sum_t   s3_num_d;
  lpi_pkg::sum_t   s3_den_d;

  assign s3_num_d = lpi_pkg::sum_t'(s2_nprod_q[0]) + lpi_pkg::sum_t'(s2_nprod_q[1])
                  + lpi_pkg::sum_t'(s2_nprod_q[2])
                  + (lpi_pkg::sum_t'(offset_q) <<< lpi_pkg::FRAC_W);
  assign s3_den_d = lpi_pkg::sum_t'(s2_dprod_q[0]) + lpi_pkg::sum_t'(s2_dprod_q[1])
                  + lpi_pkg::sum_t'(s2_dprod_q[2]);

  // ------------------------------------------------------------------
  // Stage 4: split into sign and magnitude; flag a zero denominator.
  // ------------------------------------------------------------------
  logic              s4_valid_q;
  lpi_pkg::coord_t   s4_pt_q   [L];
  lpi_pkg::dirmag_t  s4_dmag_q [L];
  logic [L-1:0]      s4_neg_q;
  lpi_pkg::nmag_t    s4_num_q;
  lpi_pkg::dmag_t    s4_den_q;
  logic              s4_par_q;
  lpi_pkg::dirmag_t  s4_dmag_d [L];
  logic [L-1:0]      s4_neg_d;
  lpi_pkg::nmag_t    s4_num_d;
  lpi_pkg::dmag_t    s4_den_d;
  logic              s4_par_d;

  always_comb begin
    logic          num_neg;
    logic          den_neg;
    lpi_pkg::sum_t num_abs;
    lpi_pkg::sum_t den_abs;
    lpi_pkg::dir_t dir_abs;
    num_neg  = s3_num_q[lpi_pkg::SUM_W-1];
    den_neg  = s3_den_q[lpi_pkg::SUM_W-1];
    num_abs  = num_neg ? -s3_num_q : s3_num_q;
    den_abs  = den_neg ? -s3_den_q : s3_den_q;
    s4_num_d = num_abs[lpi_pkg::NUM_W-1:0];
    s4_den_d = den_abs[lpi_pkg::DEN_W-1:0];
    s4_par_d = (s3_den_q == '0);
    for (int i = 0; i < L; i++) begin
      dir_abs      = s3_dir_q[i][lpi_pkg::DIR_W-1] ? -s3_dir_q[i] : s3_dir_q[i];
      s4_dmag_d[i] = lpi_pkg::dirmag_t'(dir_abs);
      // Sign of the offset term Dir_i * num / den
      s4_neg_d[i]  = s3_dir_q[i][lpi_pkg::DIR_W-1] ^ num_neg ^ den_neg;
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: |Dir_i| * |num| as two 33x32 partial products per axis.
  // ------------------------------------------------------------------
  logic            s5_valid_q;
  lpi_pkg::coord_t s5_pt_q   [L];
  logic [L-1:0]    s5_neg_q;
  lpi_pkg::dmag_t  s5_den_q;
  logic            s5_par_q;
  lpi_pkg::pp_t    s5_pplo_q [L];
  lpi_pkg::pp_t    s5_pphi_q [L];
  lpi_pkg::pp_t    s5_pplo_d [L];
  lpi_pkg::pp_t    s5_pphi_d [L];

  always_comb begin
    for (int i = 0; i < L; i++) begin
      s5_pplo_d[i] = s4_dmag_q[i] * s4_num_q[lpi_pkg::HALF_W-1:0];
      s5_pphi_d[i] = s4_dmag_q[i] * s4_num_q[lpi_pkg::NUM_W-1:lpi_pkg::HALF_W];
    end
  end

  // ------------------------------------------------------------------
  // Stage 6: merge the partial products into the 97-bit dividend.
  // ------------------------------------------------------------------
  logic            s6_valid_q;
  lpi_pkg::coord_t s6_pt_q   [L];
  logic [L-1:0]    s6_neg_q;
  lpi_pkg::dmag_t  s6_den_q;
  logic            s6_par_q;
  lpi_pkg::prod_t  s6_prod_q [L];
  lpi_pkg::prod_t  s6_prod_d [L];

  always_comb begin
    for (int i = 0; i < L; i++) begin
      s6_prod_d[i] = {s5_pphi_q[i], {lpi_pkg::HALF_W{1'b0}}}
                   + lpi_pkg::prod_t'(s5_pplo_q[i]);
    end
  end

  // ------------------------------------------------------------------
  // Stage 7: load the divider. A quotient of 2^41 or more clamps anyway,
  // so test for it up front and keep 41 quotient bits per axis.
  // ------------------------------------------------------------------
  logic               s7_valid_q;
  lpi_pkg::lpi_div_t  s7_div_q;
  lpi_pkg::lpi_side_t s7_side_q;
  lpi_pkg::lpi_div_t  s7_div_d;
  lpi_pkg::lpi_side_t s7_side_d;

  always_comb begin
    lpi_pkg::dmag_t high;
    logic           ovf;
    s7_div_d.den       = s6_den_q;
    s7_side_d.parallel = s6_par_q;
    s7_side_d.neg      = s6_neg_q;
    for (int i = 0; i < L; i++) begin
      high = lpi_pkg::dmag_t'(s6_prod_q[i][lpi_pkg::PROD_W-1:lpi_pkg::QUO_W]);
      ovf  = (high >= s6_den_q);
      s7_side_d.ovf[i] = ovf;
      s7_side_d.pt[i]  = s6_pt_q[i];
      s7_div_d.rem[i]  = ovf ? '0 : high;
      s7_div_d.nq[i]   = s6_prod_q[i][lpi_pkg::QUO_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // Valid chain of the front stages
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
      s7_valid_q <= s6_valid_q;
    end
  end

  // Front-stage payload: advance every cycle, no reset.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < L; i++) begin
      s1_pt_q[i]    <= in_first[i];
      s1_dir_q[i]   <= s1_dir_d[i];
      s2_pt_q[i]    <= s1_pt_q[i];
      s2_dir_q[i]   <= s1_dir_q[i];
      s2_nprod_q[i] <= s2_nprod_d[i];
      s2_dprod_q[i] <= s2_dprod_d[i];
      s3_pt_q[i]    <= s2_pt_q[i];
      s3_dir_q[i]   <= s2_dir_q[i];
      s4_pt_q[i]    <= s3_pt_q[i];
      s4_dmag_q[i]  <= s4_dmag_d[i];
      s5_pt_q[i]    <= s4_pt_q[i];
      s5_pplo_q[i]  <= s5_pplo_d[i];
      s5_pphi_q[i]  <= s5_pphi_d[i];
      s6_pt_q[i]    <= s5_pt_q[i];
      s6_prod_q[i]  <= s6_prod_d[i];
    end
    s3_num_q  <= s3_num_d;
    s3_den_q  <= s3_den_d;
    s4_neg_q  <= s4_neg_d;
    s4_num_q  <= s4_num_d;
    s4_den_q  <= s4_den_d;
    s4_par_q  <= s4_par_d;
    s5_neg_q  <= s4_neg_q;
    s5_den_q  <= s4_den_q;
    s5_par_q  <= s4_par_q;
    s6_neg_q  <= s5_neg_q;
    s6_den_q  <= s5_den_q;
    s6_par_q  <= s5_par_q;
    s7_div_q  <= s7_div_d;
    s7_side_q <= s7_side_d;
  end

  // ------------------------------------------------------------------
  // Divider: 41 stages, one quotient bit each
  // ------------------------------------------------------------------
  logic               dv_valid;
  lpi_pkg::lpi_div_t  dv_div;
  lpi_pkg::lpi_side_t dv_side;

  lpi_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s7_valid_q),
    .div_i   (s7_div_q),
    .side_i  (s7_side_q),
    .valid_o (dv_valid),
    .div_o   (dv_div),
    .side_o  (dv_side)
  );

  // ------------------------------------------------------------------
  // Finish stage 1: clamp the offset at 2^40 and apply it to the point.
  // ------------------------------------------------------------------
  logic          fh_valid_q;
  logic          fh_par_q;
  lpi_pkg::hit_t fh_hit_q [L];
  lpi_pkg::hit_t fh_hit_d [L];

  always_comb begin
    lpi_pkg::quo_t   qm;
    lpi_pkg::coord_t pt;
    for (int i = 0; i < L; i++) begin
      qm = (dv_side.ovf[i] || dv_div.nq[i] > lpi_pkg::Q_CLAMP)
         ? lpi_pkg::Q_CLAMP : dv_div.nq[i];
      pt = lpi_pkg::coord_t'(dv_side.pt[i]);
      fh_hit_d[i] = dv_side.neg[i]
                  ? lpi_pkg::hit_t'(pt) + lpi_pkg::hit_t'(qm)
                  : lpi_pkg::hit_t'(pt) - lpi_pkg::hit_t'(qm);
    end
  end

  // ------------------------------------------------------------------
  // Finish stage 2: saturate to 32 bits; zero the coordinates and the saturation flag when parallel.
  // ------------------------------------------------------------------
  logic            out_valid_q;
  logic            out_par_q;
  logic            out_sat_q;
  lpi_pkg::coord_t out_hit_q [L];
  lpi_pkg::coord_t out_hit_d [L];
  logic            out_sat_d;

  always_comb begin
    logic hi_ov;
    logic lo_ov;
    out_sat_d = 1'b0;
    for (int i = 0; i < L; i++) begin
      hi_ov = !fh_hit_q[i][lpi_pkg::HIT_W-1]
            && (|fh_hit_q[i][lpi_pkg::HIT_W-2:lpi_pkg::COORD_W-1]);
      lo_ov = fh_hit_q[i][lpi_pkg::HIT_W-1]
            && !(&fh_hit_q[i][lpi_pkg::HIT_W-2:lpi_pkg::COORD_W-1]);
      if (fh_par_q) begin
        out_hit_d[i] = '0;
      end else if (hi_ov) begin
        out_hit_d[i] = lpi_pkg::COORD_MAX;
      end else if (lo_ov) begin
        out_hit_d[i] = lpi_pkg::COORD_MIN;
      end else begin
        out_hit_d[i] = lpi_pkg::coord_t'(fh_hit_q[i][lpi_pkg::COORD_W-1:0]);
      end
      out_sat_d = out_sat_d || (!fh_par_q && (hi_ov || lo_ov));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fh_valid_q  <= dv_valid;
      out_valid_q <= fh_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < L; i++) begin
      fh_hit_q[i]  <= fh_hit_d[i];
      out_hit_q[i] <= out_hit_d[i];
    end
    fh_par_q  <= dv_side.parallel;
    out_par_q <= fh_par_q;
    out_sat_q <= out_sat_d;
  end

  // Each result shows for exactly one cycle.
  assign valid_o     = out_valid_q;
  assign hit_x_o     = out_hit_q[0];
  assign hit_y_o     = out_hit_q[1];
  assign hit_z_o     = out_hit_q[2];
  assign parallel_o  = out_par_q;
  assign saturated_o = out_sat_q;

  `LPI_ASSERT_IMP(a_parallel_zero, valid_o && parallel_o, hit_x_o == '0 && hit_y_o == '0 && hit_z_o == '0 && !saturated_o, "parallel result not cleared")
  `LPI_ASSERT_IMP(a_sat_at_bound, valid_o && saturated_o, hit_x_o == lpi_pkg::COORD_MAX || hit_x_o == lpi_pkg::COORD_MIN || hit_y_o == lpi_pkg::COORD_MAX || hit_y_o == lpi_pkg::COORD_MIN || hit_z_o == lpi_pkg::COORD_MAX || hit_z_o == lpi_pkg::COORD_MIN, "saturated flag without a clipped coordinate")
  `LPI_ASSERT_NEXT(a_busy_stays_low, !busy, !busy, "busy rose after reset")

endmodule
`default_nettype wire

FILE: tb/sv/tb_line_plane_intersection_unit.sv
// Self-checking testbench for the line and plane intersection unit
`timescale 1ns / 1ps
module tb_line_plane_intersection_unit;

  // Line form carried on func_i
  typedef enum logic {
    FORM_POINT_DIR  = 1'b0,
    FORM_TWO_POINTS = 1'b1
  } line_form_e;

  // Register indexes on the configuration write channel
  typedef enum logic [1:0] {
    REG_NORMAL_A = 2'd0,
    REG_NORMAL_B = 2'd1,
    REG_NORMAL_C = 2'd2,
    REG_OFFSET_D = 2'd3
  } plane_reg_e;

  // How the sender spaces its items
  typedef enum int {
    GAP_NONE,
    GAP_RANDOM,
    GAP_SPARSE
  } gap_mode_e;

  // Flavors of random line items
  typedef enum int {
    LINE_AIMED,
    LINE_PARALLEL,
    LINE_EXTREME,
    LINE_RANDOM
  } line_kind_e;

  typedef struct {
    line_form_e      form;
    lpi_pkg::coord_t first [3];
    lpi_pkg::coord_t second [3];
  } line_item_t;

  typedef struct {
    lpi_pkg::coord_t hit [3];
    logic            parallel;
    logic            saturated;
  } plane_hit_t;

  localparam int              PLANE_PHASES    = 10;
  localparam int              ITEMS_PER_PHASE = 105;
  localparam int              DRAIN_CYCLES    = 64;  // longer than the pipeline
  localparam int              MAX_REPORTS     = 40;
  localparam lpi_pkg::coord_t ONE             = 32'sh0001_0000;

  // DUT signals; every input starts at a known value
  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  logic            func_i      = 1'b0;
  lpi_pkg::coord_t first_x_i   = '0;
  lpi_pkg::coord_t first_y_i   = '0;
  lpi_pkg::coord_t first_z_i   = '0;
  lpi_pkg::coord_t second_x_i  = '0;
  lpi_pkg::coord_t second_y_i  = '0;
  lpi_pkg::coord_t second_z_i  = '0;
  logic            valid_o;
  lpi_pkg::coord_t hit_x_o;
  lpi_pkg::coord_t hit_y_o;
  lpi_pkg::coord_t hit_z_o;
  logic            parallel_o;
  logic            saturated_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [1:0]      cfg_index_i = REG_NORMAL_A;
  lpi_pkg::coord_t cfg_data_i  = '0;

  // Shadow of the plane registers, updated when a write is accepted
  lpi_pkg::coord_t plane_coef [4];

  line_item_t pending_lines [$];   // items waiting for the driver
  plane_hit_t hit_expect_q [$];    // predicted results, oldest first
  line_item_t line_on_port;
  gap_mode_e  gap_mode = GAP_SPARSE;
  int         gap_left;
  int         fail_cnt       = 0;
  int         lines_taken    = 0;
  int         hits_checked   = 0;
  int         parallel_seen  = 0;
  int         saturated_seen = 0;
  int         plane_settings = 1;

  line_plane_intersection_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .first_x_i   (first_x_i),
    .first_y_i   (first_y_i),
    .first_z_i   (first_z_i),
    .second_x_i  (second_x_i),
    .second_y_i  (second_y_i),
    .second_z_i  (second_z_i),
    .valid_o     (valid_o),
    .hit_x_o     (hit_x_o),
    .hit_y_o     (hit_y_o),
    .hit_z_o     (hit_z_o),
    .parallel_o  (parallel_o),
    .saturated_o (saturated_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Intersection of one line with the current plane.
  // Both dot products are exact at 128 bits; the offset along each axis is
  // |dir| * |num| / |den|, truncated toward zero, clamped at 2^40, and the
  // sum with the point saturates to 32 bits.
  function automatic plane_hit_t intersect_plane(line_item_t ln);
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic signed [127:0] h;
    logic [127:0]        num_mag;
    logic [127:0]        den_mag;
    logic [127:0]        dir_mag;
    logic [127:0]        q;
    logic signed [63:0]  dir [3];
    logic                num_neg;
    logic                den_neg;
    logic                neg;
    plane_hit_t          r;
    int                  i;
    num = 128'(plane_coef[REG_OFFSET_D]) <<< lpi_pkg::FRAC_W;
    den = '0;
    for (i = 0; i < 3; i++) begin
      dir[i] = ln.second[i];
      if (ln.form == FORM_TWO_POINTS) dir[i] = dir[i] - 64'(ln.first[i]);
      num = num + plane_coef[i] * 128'(ln.first[i]);
      den = den + plane_coef[i] * 128'(dir[i]);
    end
    r.parallel  = (den == 0);
    r.saturated = 1'b0;
    num_neg = (num < 0);
    den_neg = (den < 0);
    num_mag = num_neg ? -num : num;
    den_mag = den_neg ? -den : den;
    for (i = 0; i < 3; i++) begin
      r.hit[i] = '0;
      // a parallel line (zero denominator) leaves all coordinates at zero
      if (!r.parallel) begin
        neg     = (dir[i] < 0) ^ num_neg ^ den_neg;
        dir_mag = (dir[i] < 0) ? -dir[i] : dir[i];
        q       = (dir_mag * num_mag) / den_mag;
        if (q > (128'(1) << lpi_pkg::CLAMP_LOG2)) q = 128'(1) << lpi_pkg::CLAMP_LOG2;
        h = neg ? 128'(ln.first[i]) + $signed(q) : 128'(ln.first[i]) - $signed(q);
        if (h > 128'(lpi_pkg::COORD_MAX)) begin
          h           = 128'(lpi_pkg::COORD_MAX);
          r.saturated = 1'b1;
        end else if (h < 128'(lpi_pkg::COORD_MIN)) begin
          h           = 128'(lpi_pkg::COORD_MIN);
          r.saturated = 1'b1;
        end
        r.hit[i] = h[31:0];
      end
    end
    return r;
  endfunction

  // Signed random value within +/- 2^span_log2
  function automatic lpi_pkg::coord_t scaled_rand(int span_log2);
    logic signed [31:0] v;
    v = $urandom;
    return v >>> (31 - span_log2);
  endfunction

  function automatic lpi_pkg::coord_t pick_extreme();
    case ($urandom_range(0, 5))
      0: return lpi_pkg::COORD_MIN;
      1: return lpi_pkg::COORD_MAX;
      2: return '0;
      3: return '1;
      4: return 32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Random line: mostly moderate values that land on the plane, plus lines
  // built parallel to the current plane, extremes, and raw noise
  function automatic line_item_t make_line();
    line_item_t      ln;
    line_kind_e      kind;
    lpi_pkg::coord_t step [3];
    int              roll;
    int              i;
    roll    = $urandom_range(0, 99);
    kind    = roll < 40 ? LINE_AIMED : roll < 55 ? LINE_PARALLEL :
              roll < 75 ? LINE_EXTREME : LINE_RANDOM;
    ln.form = line_form_e'($urandom_range(0, 1));
    for (i = 0; i < 3; i++) begin
      case (kind)
        LINE_AIMED, LINE_PARALLEL: begin
          ln.first[i]  = scaled_rand(22);
          ln.second[i] = scaled_rand(20);
        end
        LINE_EXTREME: begin
          ln.first[i]  = pick_extreme();
          ln.second[i] = pick_extreme();
        end
        default: begin
          ln.first[i]  = $urandom;
          ln.second[i] = $urandom;
        end
      endcase
    end
    if (kind == LINE_PARALLEL) begin
      // cross the normal with an axis so that n.dir cancels exactly
      case ($urandom_range(0, 3))
        0: step = '{plane_coef[REG_NORMAL_B], -plane_coef[REG_NORMAL_A], '0};
        1: step = '{plane_coef[REG_NORMAL_C], '0, -plane_coef[REG_NORMAL_A]};
        2: step = '{'0, plane_coef[REG_NORMAL_C], -plane_coef[REG_NORMAL_B]};
        default: step = '{'0, '0, '0};
      endcase
      for (i = 0; i < 3; i++)
        ln.second[i] = (ln.form == FORM_TWO_POINTS) ? ln.first[i] + step[i] : step[i];
    end
    return ln;
  endfunction

  function automatic int draw_gap();
    case (gap_mode)
      GAP_NONE:   return 0;
      GAP_SPARSE: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
      default:    return $urandom_range(0, 12);
    endcase
  endfunction

  task automatic queue_line(line_form_e form,
                            lpi_pkg::coord_t px, lpi_pkg::coord_t py, lpi_pkg::coord_t pz,
                            lpi_pkg::coord_t sx, lpi_pkg::coord_t sy, lpi_pkg::coord_t sz);
    line_item_t ln;
    ln.form   = form;
    ln.first  = '{px, py, pz};
    ln.second = '{sx, sy, sz};
    pending_lines.push_back(ln);
  endtask

  // Hold until no item is queued, on the port, or in flight
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_lines.size() != 0 || start || hit_expect_q.size() != 0);
  endtask

  // Write all four plane registers back to back; keep valid high between them
  task automatic write_plane(lpi_pkg::coord_t vals [4]);
    int k;
    @(posedge clk_i);
    for (k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= plane_reg_e'(k);
      cfg_data_i  <= vals[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      plane_coef[k] = vals[k];
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic flag_field(string field, logic signed [63:0] want, logic signed [63:0] got);
    if (fail_cnt < MAX_REPORTS) $error("%s: expected %0d, got %0d", field, want, got);
    fail_cnt++;
  endtask

  // Driver: predict at the edge that takes an item, then present the next one
  // or idle for the drawn number of cycles
  always @(posedge clk_i or negedge rst_ni) begin : line_driver
    line_item_t nxt;
    if (!rst_ni) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        hit_expect_q.push_back(intersect_plane(line_on_port));
        lines_taken++;
      end
      if (start && busy) begin
        // hold the item until the unit takes it
      end else if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_lines.size() != 0) begin
        nxt = pending_lines.pop_front();
        line_on_port <= nxt;
        func_i       <= nxt.form;
        first_x_i    <= nxt.first[0];
        first_y_i    <= nxt.first[1];
        first_z_i    <= nxt.first[2];
        second_x_i   <= nxt.second[0];
        second_y_i   <= nxt.second[1];
        second_z_i   <= nxt.second[2];
        start        <= 1'b1;
        gap_left     <= draw_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result must match the oldest prediction
  always @(posedge clk_i) begin : hit_monitor
    plane_hit_t      want_hit;
    lpi_pkg::coord_t got_hit [3];
    string           lane_name [3];
    int              i;
    lane_name = '{"hit_x", "hit_y", "hit_z"};
    if (rst_ni && valid_o) begin
      got_hit = '{hit_x_o, hit_y_o, hit_z_o};
      if (hit_expect_q.size() == 0) begin
        if (fail_cnt < MAX_REPORTS)
          $error("result with no item outstanding: hit %0d %0d %0d",
                 hit_x_o, hit_y_o, hit_z_o);
        fail_cnt++;
      end else begin
        want_hit = hit_expect_q.pop_front();
        for (i = 0; i < 3; i++)
          if (got_hit[i] !== want_hit.hit[i]) flag_field(lane_name[i], want_hit.hit[i], got_hit[i]);
        if (parallel_o !== want_hit.parallel)
          flag_field("parallel", want_hit.parallel, parallel_o);
        if (saturated_o !== want_hit.saturated)
          flag_field("saturated", want_hit.saturated, saturated_o);
        hits_checked++;
        if (parallel_o === 1'b1) parallel_seen++;
        if (saturated_o === 1'b1) saturated_seen++;
      end
    end
  end

  initial begin : stimulus
    lpi_pkg::coord_t plane_vals [4];
    lpi_pkg::coord_t mx;
    lpi_pkg::coord_t mn;
    int              ph;
    int              k;
    int              n;
    mx = lpi_pkg::COORD_MAX;
    mn = lpi_pkg::COORD_MIN;
    plane_coef = '{'0, '0, lpi_pkg::NORMAL_C_RST, '0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed lines against the reset plane z = 0
    gap_mode = GAP_SPARSE;
    queue_line(FORM_POINT_DIR, ONE, 2 * ONE, 3 * ONE, '0, '0, -ONE);
    queue_line(FORM_TWO_POINTS, '0, '0, 4 * ONE, 2 * ONE, 2 * ONE, 2 * ONE);
    // zero direction, direction inside the plane, equal points, line in plane
    queue_line(FORM_POINT_DIR, ONE, ONE, ONE, '0, '0, '0);
    queue_line(FORM_POINT_DIR, '0, '0, ONE, ONE, -ONE, '0);
    queue_line(FORM_TWO_POINTS, ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE);
    queue_line(FORM_TWO_POINTS, ONE, '0, '0, 5 * ONE, 3 * ONE, '0);
    // truncation toward zero on both signs
    queue_line(FORM_POINT_DIR, '0, '0, 32'sd1, 32'sd1, -32'sd1, 32'sd3);
    queue_line(FORM_POINT_DIR, '0, '0, -32'sd1, -32'sd1, 32'sd1, -32'sd3);
    // field extremes, 33-bit differences and clipping
    queue_line(FORM_POINT_DIR, mx, mx, mx, mn, mn, mn);
    queue_line(FORM_POINT_DIR, mn, mn, mn, mx, mx, mx);
    queue_line(FORM_POINT_DIR, '0, '0, mx, mx, mn, 32'sd1);
    queue_line(FORM_TWO_POINTS, mn, mn, mn, mx, mx, mx);
    queue_line(FORM_TWO_POINTS, mx, mx, mx, mn, mn, mn);
    queue_line(FORM_POINT_DIR, '1, '1, '1, '1, '1, '1);
    queue_line(FORM_POINT_DIR, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
               32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_line(FORM_TWO_POINTS, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
               32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_line(FORM_POINT_DIR, '0, '0, 32'sd1, mx, mn, -32'sd1);
    queue_line(FORM_POINT_DIR, '0, '0, mn, 32'sd1, 32'sd1, 32'sd1);
    wait_idle();

    // Random lines against a series of planes, extremes among them
    for (ph = 0; ph < PLANE_PHASES; ph++) begin
      case (ph)
        0: plane_vals = '{'0, '0, ONE, 5 * ONE};
        2: plane_vals = '{mx, mx, mx, mx};
        3: plane_vals = '{mn, mn, mn, mn};
        4: for (k = 0; k < 4; k++) plane_vals[k] = pick_extreme();
        5: for (k = 0; k < 4; k++) plane_vals[k] = $urandom;
        7: plane_vals = '{ONE, -ONE, ONE / 2, -3 * ONE};
        9: plane_vals = '{'0, '0, '0, $urandom};  // degenerate normal: all parallel
        default: begin
          for (k = 0; k < 4; k++)
            plane_vals[k] = scaled_rand(k == int'(REG_OFFSET_D) ? 24 : 18);
        end
      endcase
      write_plane(plane_vals);
      plane_settings++;
      @(negedge clk_i);
      gap_mode = gap_mode_e'(ph % 3);
      n = (ph == 9) ? 40 : ITEMS_PER_PHASE;
      for (k = 0; k < n; k++) pending_lines.push_back(make_line());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d of %0d line items over %0d plane settings.",
             hits_checked, lines_taken, plane_settings);
    $display("Results flagged parallel: %0d, saturated: %0d.", parallel_seen, saturated_seen);
    if (fail_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/lpi_pkg.sv
hdl/lpi_div_pipe.sv
hdl/line_plane_intersection_unit.sv
tb/sv/tb_line_plane_intersection_unit.sv
